[design/hgt_pkg.sv]
// shared widths, types and register codes for the hydrogen bond geometry test
package hgt_pkg;

  localparam int COORD_WIDTH = 24;
  localparam int DW          = COORD_WIDTH + 1;
  localparam int BOX_W       = 23;
  localparam int REM_W       = BOX_W + 1;
  localparam int DSTEPS      = 4;
  localparam int NDIV        = (COORD_WIDTH + DSTEPS - 1) / DSTEPS;
  localparam int MP_W        = NDIV * DSTEPS;
  localparam int FOLD_LAT    = NDIV + 1;

  localparam int VLIM_W      = 18;
  localparam int FV_W        = VLIM_W + 2;
  localparam int FM_W        = VLIM_W + 1;
  localparam int VSQ_W       = 2 * FM_W;
  localparam int VV_W        = VSQ_W + 2;
  localparam int VH_W        = VV_W / 2;
  localparam int USQ_W       = 2 * COORD_WIDTH;
  localparam int UU_W        = USQ_W + 2;
  localparam int DP_W        = DW + FV_W;
  localparam int DOT_W       = DP_W + 2;
  localparam int DM_W        = DOT_W - 1;
  localparam int DH_W        = (DM_W + 1) / 2;
  localparam int DSQ_W       = 4 * DH_W;

  localparam int CUT_W       = 36;
  localparam int COS_W       = 17;
  localparam int C2_W        = 2 * COS_W;
  localparam int Q_W         = C2_W + VH_W;
  localparam int CV_W        = C2_W + VV_W;
  localparam int CP_W        = (CV_W + 2) / 3;
  localparam int UP_W        = (UU_W + 1) / 2;
  localparam int PP_W        = CP_W + UP_W;
  localparam int ACC_W       = 3 * CP_W + UP_W;
  localparam int COS_SH      = 30;
  localparam int LHS_W       = DSQ_W + COS_SH;
  localparam int RHS_W       = 3 * CP_W + 2 * UP_W;
  localparam int CMP_W       = (LHS_W > RHS_W) ? LHS_W : RHS_W;

  localparam logic [CUT_W-1:0] DIST2_RST = CUT_W'(12845056);
  localparam logic [COS_W-1:0] COS_RST   = COS_W'(30792);
  localparam logic [BOX_W-1:0] BOX_RST   = BOX_W'(8388607);

  typedef enum logic [2:0] {
    CFG_DIST2    = 3'd0,
    CFG_COS      = 3'd1,
    CFG_PERIODIC = 3'd2,
    CFG_BOX_X    = 3'd3,
    CFG_BOX_Y    = 3'd4,
    CFG_BOX_Z    = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic rej;
    logic pos;
    logic cneg;
  } flg_t;

endpackage

[design/hgt_fold.sv]
// one axis of the minimum image fold: pipelined remainder by the box length
module hgt_fold (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [hgt_pkg::DW-1:0]   v_in,
  input  logic [hgt_pkg::BOX_W-1:0]       box,
  input  logic                            periodic,
  output logic signed [hgt_pkg::FV_W-1:0] fv,
  output logic                            over
);
  import hgt_pkg::*;

  logic [REM_W-1:0]     rem_r [NDIV];
  logic [MP_W-1:0]      m_r   [NDIV];
  logic signed [DW-1:0] vs_r  [NDIV];
  logic [DW-1:0]        vmag;
  logic signed [FV_W-1:0] fv_r;
  logic                 over_r;

  assign vmag = v_in[DW-1] ? DW'(-v_in) : DW'(v_in);

  for (genvar s = 0; s < NDIV; s++) begin : g_div
    logic [REM_W-1:0]     rem_in, rem_c;
    logic [MP_W-1:0]      m_in, m_c;
    logic signed [DW-1:0] vv_in;
    if (s == 0) begin : g_first
      assign rem_in = '0;
      assign m_in   = MP_W'(vmag[COORD_WIDTH-1:0]);
      assign vv_in  = v_in;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign m_in   = m_r[s-1];
      assign vv_in  = vs_r[s-1];
    end
    // restoring steps, one quotient bit each
    always_comb begin
      rem_c = rem_in;
      m_c   = m_in;
      for (int k = 0; k < DSTEPS; k++) begin
        rem_c = {rem_c[REM_W-2:0], m_c[MP_W-1]};
        m_c   = {m_c[MP_W-2:0], 1'b0};
        if (rem_c >= REM_W'(box)) begin
          rem_c = rem_c - REM_W'(box);
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= rem_c;
        m_r[s]   <= m_c;
        vs_r[s]  <= vv_in;
      end
    end
  end

  logic [BOX_W-1:0]     r;
  logic                 half;
  logic signed [DW-1:0] vl, res, sres, fres;
  logic [DW-1:0]        fmag;

  assign r    = rem_r[NDIV-1][BOX_W-1:0];
  assign half = {r, 1'b0} >= {1'b0, box};
  assign vl   = vs_r[NDIV-1];

  always_comb begin
    // round half away from zero: a remainder of half a box or more wraps to the other side
    res  = half ? $signed(DW'(r) - DW'(box)) : $signed(DW'(r));
    sres = vl[DW-1] ? -res : res;
    fres = (periodic && (box != '0)) ? sres : vl;
    fmag = fres[DW-1] ? DW'(-fres) : DW'(fres);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fv_r   <= FV_W'(fres);
      over_r <= fmag > (DW'(1) << VLIM_W);
    end
  end

  assign fv   = fv_r;
  assign over = over_r;

endmodule

[design/hbond_geometry_test.sv]
// hydrogen bond geometry test: distance cutoff and exact cosine cutoff per atom triple
// pipeline: 1 input stage, 7 fold stages (6 remainder stages of 4 bits each and a rounding stage),
//   8 arithmetic stages and an output stage
// throughput: one triple per cycle; a stalled result freezes the whole pipeline
// reset: synchronous active-low rst_n clears all valid bits and loads register defaults
module hbond_geometry_test (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_donor_x,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_donor_y,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_donor_z,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_hyd_x,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_hyd_y,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_hyd_z,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_acc_x,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_acc_y,
  input  logic signed [hgt_pkg::COORD_WIDTH-1:0] in_acc_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_bonded,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [hgt_pkg::CUT_W-1:0]           cfg_data
);
  import hgt_pkg::*;

  // configuration registers
  logic [CUT_W-1:0] dist2_r;
  logic [COS_W-1:0] cos_r;
  logic             periodic_r;
  logic [BOX_W-1:0] box_r [3];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist2_r    <= DIST2_RST;
      cos_r      <= COS_RST;
      periodic_r <= 1'b0;
      box_r[0]   <= BOX_RST;
      box_r[1]   <= BOX_RST;
      box_r[2]   <= BOX_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DIST2:    dist2_r    <= cfg_data;
        CFG_COS:      cos_r      <= cfg_data[COS_W-1:0];
        CFG_PERIODIC: periodic_r <= cfg_data[0];
        CFG_BOX_X:    box_r[0]   <= cfg_data[BOX_W-1:0];
        CFG_BOX_Y:    box_r[1]   <= cfg_data[BOX_W-1:0];
        CFG_BOX_Z:    box_r[2]   <= cfg_data[BOX_W-1:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // input stage: difference vectors
  logic signed [COORD_WIDTH-1:0] d_in [3], h_in [3], a_in [3];
  logic signed [DW-1:0] u1_r [3], v1_r [3];
  logic                 vld1_r;

  assign d_in = '{in_donor_x, in_donor_y, in_donor_z};
  assign h_in = '{in_hyd_x, in_hyd_y, in_hyd_z};
  assign a_in = '{in_acc_x, in_acc_y, in_acc_z};

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        u1_r[i] <= DW'(h_in[i]) - DW'(d_in[i]);
        v1_r[i] <= DW'(a_in[i]) - DW'(h_in[i]);
      end
    end
  end

  // fold units and the matching delay line for u
  logic signed [FV_W-1:0] fv [3];
  logic                   ovr [3];
  logic signed [DW-1:0]   ud_r [FOLD_LAT][3];
  logic [FOLD_LAT-1:0]    vd_r;

  for (genvar i = 0; i < 3; i++) begin : g_ax
    hgt_fold u_fold (
      .clk      (clk),
      .en       (adv),
      .v_in     (v1_r[i]),
      .box      (box_r[i]),
      .periodic (periodic_r),
      .fv       (fv[i]),
      .over     (ovr[i])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ud_r[0] <= u1_r;
      for (int s = 1; s < FOLD_LAT; s++) begin
        ud_r[s] <= ud_r[s-1];
      end
    end
  end

  // arithmetic stages m1..m8
  logic [8:1] vm_r;
  logic       out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r    <= 1'b0;
      vd_r      <= '0;
      vm_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      vld1_r    <= in_valid;
      vd_r      <= {vd_r[FOLD_LAT-2:0], vld1_r};
      vm_r      <= {vm_r[7:1], vd_r[FOLD_LAT-1]};
      out_vld_r <= vm_r[8];
    end
  end

  // m1: squares and dot terms
  logic [VSQ_W-1:0]       vsq_r [3];
  logic [USQ_W-1:0]       usq_r [3];
  logic signed [DP_W-1:0] dp_r  [3];
  logic                   ov1_r;
  logic [FV_W-1:0]        fvm [3];
  logic [DW-1:0]          um  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fvm[i] = fv[i][FV_W-1] ? FV_W'(-fv[i]) : FV_W'(fv[i]);
      um[i]  = ud_r[FOLD_LAT-1][i][DW-1] ? DW'(-ud_r[FOLD_LAT-1][i])
                                          : DW'(ud_r[FOLD_LAT-1][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        vsq_r[i] <= fvm[i][FM_W-1:0] * fvm[i][FM_W-1:0];
        usq_r[i] <= um[i][COORD_WIDTH-1:0] * um[i][COORD_WIDTH-1:0];
        dp_r[i]  <= DP_W'(ud_r[FOLD_LAT-1][i]) * DP_W'(fv[i]);
      end
      ov1_r <= ovr[0] | ovr[1] | ovr[2];
    end
  end

  // m2: sums
  logic [VV_W-1:0]         vv2_r;
  logic [UU_W-1:0]         uu2_r;
  logic signed [DOT_W-1:0] dot2_r;
  logic                    ov2_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      vv2_r  <= VV_W'(vsq_r[0]) + VV_W'(vsq_r[1]) + VV_W'(vsq_r[2]);
      uu2_r  <= UU_W'(usq_r[0]) + UU_W'(usq_r[1]) + UU_W'(usq_r[2]);
      dot2_r <= DOT_W'(dp_r[0]) + DOT_W'(dp_r[1]) + DOT_W'(dp_r[2]);
      ov2_r  <= ov1_r;
    end
  end

  // m3: early reject, magnitudes, squared threshold
  logic [DM_W-1:0]  dm3_r;
  logic [C2_W-1:0]  c23_r;
  logic [VV_W-1:0]  vv3_r;
  logic [UU_W-1:0]  uu3_r;
  flg_t             f3_r;
  logic [COS_W-1:0] cm;
  logic [DOT_W-1:0] dabs;

  assign cm   = cos_r[COS_W-1] ? COS_W'(-cos_r) : cos_r;
  assign dabs = dot2_r[DOT_W-1] ? DOT_W'(-dot2_r) : DOT_W'(dot2_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      dm3_r     <= dabs[DM_W-1:0];
      c23_r     <= cm * cm;
      vv3_r     <= vv2_r;
      uu3_r     <= uu2_r;
      f3_r.rej  <= ov2_r || (vv2_r > VV_W'(dist2_r)) || (vv2_r == '0) || (uu2_r == '0);
      f3_r.pos  <= !dot2_r[DOT_W-1];
      f3_r.cneg <= cos_r[COS_W-1];
    end
  end

  // m4: partial products
  logic [2*DH_W-1:0] phh_r, phl_r, pll_r;
  logic [Q_W-1:0]    q0_r, q1_r;
  logic [UU_W-1:0]   uu4_r;
  flg_t              f4_r;
  logic [2*DH_W-1:0] dmx;

  assign dmx = (2*DH_W)'(dm3_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      phh_r <= dmx[2*DH_W-1:DH_W] * dmx[2*DH_W-1:DH_W];
      phl_r <= dmx[2*DH_W-1:DH_W] * dmx[DH_W-1:0];
      pll_r <= dmx[DH_W-1:0] * dmx[DH_W-1:0];
      q0_r  <= c23_r * vv3_r[VH_W-1:0];
      q1_r  <= c23_r * vv3_r[VV_W-1:VH_W];
      uu4_r <= uu3_r;
      f4_r  <= f3_r;
    end
  end

  // m5: dot squared and c^2 |v|^2
  logic [DSQ_W-1:0] dsq5_r;
  logic [CV_W-1:0]  cv5_r;
  logic [UU_W-1:0]  uu5_r;
  flg_t             f5_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      dsq5_r <= (DSQ_W'(phh_r) << (2*DH_W)) + (DSQ_W'(phl_r) << (DH_W+1)) + DSQ_W'(pll_r);
      cv5_r  <= CV_W'(q0_r) + (CV_W'(q1_r) << VH_W);
      uu5_r  <= uu4_r;
      f5_r   <= f4_r;
    end
  end

  // m6: c^2 |v|^2 |u|^2 as six partial products
  logic [PP_W-1:0]    pp6_r [3][2];
  logic [DSQ_W-1:0]   dsq6_r;
  flg_t               f6_r;
  logic [3*CP_W-1:0]  cvx;
  logic [2*UP_W-1:0]  uux;

  assign cvx = (3*CP_W)'(cv5_r);
  assign uux = (2*UP_W)'(uu5_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 2; j++) begin
          pp6_r[i][j] <= cvx[i*CP_W +: CP_W] * uux[j*UP_W +: UP_W];
        end
      end
      dsq6_r <= dsq5_r;
      f6_r   <= f5_r;
    end
  end

  // m7: sum along each u piece
  logic [ACC_W-1:0] acc7_r [2];
  logic [DSQ_W-1:0] dsq7_r;
  flg_t             f7_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 2; j++) begin
        acc7_r[j] <= ACC_W'(pp6_r[0][j]) + (ACC_W'(pp6_r[1][j]) << CP_W)
                   + (ACC_W'(pp6_r[2][j]) << (2*CP_W));
      end
      dsq7_r <= dsq6_r;
      f7_r   <= f6_r;
    end
  end

  // m8: both sides of the squared cosine test
  logic [CMP_W-1:0] lhs8_r, rhs8_r;
  flg_t             f8_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      rhs8_r <= CMP_W'(acc7_r[0]) + (CMP_W'(acc7_r[1]) << UP_W);
      lhs8_r <= CMP_W'(dsq7_r) << COS_SH;
      f8_r   <= f7_r;
    end
  end

  // output stage
  logic bonded_nxt, bonded_r;

  always_comb begin
    if (f8_r.rej) begin
      bonded_nxt = 1'b0;
    end else if (f8_r.pos && f8_r.cneg) begin
      bonded_nxt = 1'b1;
    end else if (!f8_r.pos && !f8_r.cneg) begin
      bonded_nxt = 1'b0;
    end else if (f8_r.pos) begin
      bonded_nxt = lhs8_r > rhs8_r;
    end else begin
      bonded_nxt = lhs8_r < rhs8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bonded_r <= bonded_nxt;
    end
  end

  assign out_valid  = out_vld_r;
  assign out_bonded = bonded_r;

  a_hold_last: assert property (@(posedge clk) disable iff (!rst_n)
    (vm_r[8] && in_stall) |=> vm_r[8])
    else $error("item in last arithmetic stage lost during stall");

  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (vm_r[8] && f8_r.rej && !in_stall) |=> (out_valid && !out_bonded))
    else $error("rejected triple reported as bonded");

  a_fold_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (vld1_r && !in_stall) |=> vd_r[0])
    else $error("item dropped entering fold pipeline");

  a_neg_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (vm_r[8] && !f8_r.rej && f8_r.pos && f8_r.cneg && !in_stall) |=> out_bonded)
    else $error("nonnegative dot with negative threshold not bonded");

endmodule

[tb/sv/hbond_geometry_test_tb.sv]
// testbench for the hydrogen bond geometry test: directed table, random triples, config phases
module hbond_geometry_test_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import hgt_pkg::*;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t triple_t [9];
  typedef struct {
    coord_t c [9];
    int     bond;
  } dir_row_t;

  localparam int  LATENCY    = 17;
  localparam int  IDLE_PCT   = 36;
  localparam int  STALL_LIM  = 5000;
  localparam int  NUM_PHASES = 7;
  localparam int  PER_PHASE  = 215;
  localparam int  NO_PREDICT = -1;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  coord_t cur [9];
  logic out_valid;
  logic out_stall;
  logic out_bonded;
  logic cfg_valid;
  logic cfg_ready;
  logic [2:0] cfg_index;
  logic [CUT_W-1:0] cfg_data;

  // shadow copy of the block's registers
  longint unsigned dist2_reg;
  longint          cos_reg;
  bit              periodic_reg;
  longint          box_reg [3];

  logic bond_q [$];
  bit   idle_on;
  int   mismatches;
  int   results_seen;
  int   bonds_seen;
  int   quiet_cycles;
  int   items_sent;
  dir_row_t dir_rows [12];

  hbond_geometry_test dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_donor_x (cur[0]),
    .in_donor_y (cur[1]),
    .in_donor_z (cur[2]),
    .in_hyd_x   (cur[3]),
    .in_hyd_y   (cur[4]),
    .in_hyd_z   (cur[5]),
    .in_acc_x   (cur[6]),
    .in_acc_y   (cur[7]),
    .in_acc_z   (cur[8]),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_bonded (out_bonded),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint abs_l(longint x);
    return (x < 0) ? -x : x;
  endfunction

  // minimum image, quotient rounded half away from zero
  function automatic longint min_image(longint x, longint box);
    longint m;
    longint n;
    longint r;
    if (box == 0) return x;
    m = abs_l(x);
    n = (2 * m + box) / (2 * box);
    r = m - n * box;
    return (x < 0) ? -r : r;
  endfunction

  function automatic logic hbond_of(triple_t t);
    longint          va [3];
    longint          ua;
    longint          dot;
    longint unsigned vv;
    logic [191:0]    uu;
    logic [191:0]    lhs;
    logic [191:0]    rhs;
    vv  = 0;
    dot = 0;
    uu  = '0;
    for (int i = 0; i < 3; i++) begin
      va[i] = longint'(t[6+i]) - longint'(t[3+i]);
      if (periodic_reg) va[i] = min_image(va[i], box_reg[i]);
      if (abs_l(va[i]) > (longint'(1) << 18)) return 1'b0;
    end
    for (int i = 0; i < 3; i++) vv += longint'(va[i] * va[i]);
    if (vv > dist2_reg || vv == 0) return 1'b0;
    for (int i = 0; i < 3; i++) begin
      ua  = longint'(t[3+i]) - longint'(t[i]);
      uu  = uu + 192'(ua * ua);
      dot = dot + ua * va[i];
    end
    if (uu == 0) return 1'b0;
    if (dot >= 0 && cos_reg < 0) return 1'b1;
    if (dot < 0 && cos_reg >= 0) return 1'b0;
    lhs = 192'(abs_l(dot)) * 192'(32768);
    lhs = lhs * lhs;
    rhs = 192'(cos_reg * cos_reg) * 192'(vv) * uu;
    return (dot >= 0) ? (lhs > rhs) : (lhs < rhs);
  endfunction

  task automatic write_reg(cfg_idx_t idx, longint unsigned val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CUT_W'(val);
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_DIST2:    dist2_reg    = val & ((64'd1 << CUT_W) - 1);
      CFG_COS:      cos_reg      = longint'(signed'(COS_W'(val)));
      CFG_PERIODIC: periodic_reg = val[0];
      CFG_BOX_X:    box_reg[0]   = val & ((64'd1 << BOX_W) - 1);
      CFG_BOX_Y:    box_reg[1]   = val & ((64'd1 << BOX_W) - 1);
      CFG_BOX_Z:    box_reg[2]   = val & ((64'd1 << BOX_W) - 1);
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // typed_bond < 0 means the predictor supplies the expectation
  task automatic send_triple(triple_t t, int typed_bond);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    cur      = t;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    bond_q.push_back((typed_bond < 0) ? hbond_of(t) : typed_bond[0]);
    items_sent++;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid = 1'b0;
    while (bond_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  function automatic triple_t rand_triple();
    triple_t t;
    longint  hv;
    longint  off;
    int      kind;
    kind = $urandom_range(99);
    for (int i = 0; i < 9; i++) t[i] = rand_coord();
    if (kind < 70) begin
      // near-bond geometry: donor and acceptor a few angstrom from the hydrogen
      for (int i = 0; i < 3; i++) begin
        hv   = longint'(t[3+i]);
        t[i] = coord_t'(hv - longint'($urandom_range(2400)) + 1200);
        off  = longint'($urandom_range(6000)) - 3000;
        if (periodic_reg && box_reg[i] != 0 && kind < 45)
          off += (longint'($urandom_range(4)) - 2) * box_reg[i];
        t[6+i] = coord_t'(hv + off);
      end
      if (kind < 5) for (int i = 0; i < 3; i++) t[i] = t[3+i];
      if (kind >= 5 && kind < 8) for (int i = 0; i < 3; i++) t[6+i] = t[3+i];
    end else if (kind < 80) begin
      // acceptor offset that may exceed the component limit or the cutoff
      for (int i = 0; i < 3; i++)
        t[6+i] = coord_t'(longint'(t[3+i]) + longint'($urandom_range(600000)) - 300000);
    end
    return t;
  endfunction

  task automatic set_phase(int p);
    case (p)
      1: begin
        write_reg(CFG_PERIODIC, 1);
        write_reg(CFG_BOX_X, 5000);
        write_reg(CFG_BOX_Y, 7000);
        write_reg(CFG_BOX_Z, 1);
      end
      2: begin
        write_reg(CFG_PERIODIC, 0);
        write_reg(CFG_COS, 64'h1_8000);
        write_reg(CFG_DIST2, (64'd1 << CUT_W) - 1);
      end
      3: begin
        write_reg(CFG_COS, 32768);
        write_reg(CFG_PERIODIC, 1);
        write_reg(CFG_BOX_X, 0);
        write_reg(CFG_BOX_Y, 8388607);
        write_reg(CFG_BOX_Z, 3000);
      end
      4: begin
        write_reg(CFG_COS, 65535);
        write_reg(CFG_DIST2, 0);
      end
      5: begin
        write_reg(CFG_COS, 64'h1_0000);
        write_reg(CFG_DIST2, 1000000);
        write_reg(CFG_PERIODIC, 0);
      end
      6: begin
        write_reg(CFG_COS, $urandom_range(65535) - 32768);
        write_reg(CFG_DIST2, $urandom_range(40000000));
        write_reg(CFG_PERIODIC, 1);
        write_reg(CFG_BOX_X, $urandom_range(9000, 2000));
        write_reg(CFG_BOX_Y, $urandom_range(9000, 2000));
        write_reg(CFG_BOX_Z, $urandom_range(9000, 2000));
      end
      default: ;
    endcase
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (out_bonded) bonds_seen++;
      if (bond_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected item: bonded=%0b", out_bonded);
      end else begin
        if (out_bonded !== bond_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("bonded mismatch: expected %0b actual %0b", bond_q[0], out_bonded);
        end
        void'(bond_q.pop_front());
      end
    end
  end

  // watchdog on cycles with no accepted item on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver stalls
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall = idle_on && ($urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < 9; i++) cur[i] = '0;
    idle_on = 1'b1;
    mismatches = 0;
    results_seen = 0;
    bonds_seen = 0;
    quiet_cycles = 0;
    items_sent = 0;
    dist2_reg = 12845056;
    cos_reg = 30792;
    periodic_reg = 1'b0;
    for (int i = 0; i < 3; i++) box_reg[i] = 8388607;

    dir_rows[0]  = '{'{0, 0, 0, 0, 0, 0, 0, 0, 0}, 0};
    dir_rows[1]  = '{'{0, 0, 0, 1024, 0, 0, 3000, 0, 0}, 1};
    dir_rows[2]  = '{'{0, 0, 0, 1024, 0, 0, 1024, 2000, 0}, 0};
    dir_rows[3]  = '{'{5, 6, 7, 5, 6, 7, 900, 6, 7}, 0};
    dir_rows[4]  = '{'{0, 0, 0, 1024, 0, 0, 4608, 0, 0}, 1};
    dir_rows[5]  = '{'{0, 0, 0, 1024, 0, 0, 4609, 0, 0}, 0};
    dir_rows[6]  = '{'{8388607, 8388607, 8388607, -8388608, -8388608, -8388608,
                       8388607, 8388607, 8388607}, 0};
    dir_rows[7]  = '{'{-8388608, -8388608, -8388608, 8388607, 8388607, 8388607,
                       8388606, 8388607, 8388607}, NO_PREDICT};
    dir_rows[8]  = '{'{2048, 0, 0, 1024, 0, 0, 3000, 0, 0}, 0};
    dir_rows[9]  = '{'{-1, -1, -1, 1000, 1000, 1000, 2000, 2100, 1900}, NO_PREDICT};
    dir_rows[10] = '{'{0, 0, 0, -8388608, 0, 0, -8386000, 300, -300}, NO_PREDICT};
    dir_rows[11] = '{'{0, 0, 0, 100, 100, 100, 1100, 1100, 1100}, 1};

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int r = 0; r < $size(dir_rows); r++) send_triple(dir_rows[r].c, dir_rows[r].bond);
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain();
        set_phase(p);
      end
      // one phase runs without any idling on either side
      idle_on = (p != 2);
      for (int n = 0; n < PER_PHASE; n++) send_triple(rand_triple(), NO_PREDICT);
      // directed rows again under this setting, checked by the predictor
      if (p > 0)
        for (int r = 0; r < $size(dir_rows); r++) send_triple(dir_rows[r].c, NO_PREDICT);
    end
    drain();

    $display("sent %0d triples over %0d register settings, %0d results, %0d bonded",
             items_sent, NUM_PHASES, results_seen, bonds_seen);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0 && bond_q.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
